>>> rtl/pts_pkg.sv
// Shared types, character codes and byte classification functions for the token scanner.
package pts_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_REAL,
        MODE_STRING,
        MODE_OP
    } scan_mode_t;

    typedef enum logic [4:0] {
        TOK_IDENT    = 5'd0,
        TOK_INT      = 5'd1,
        TOK_REAL     = 5'd2,
        TOK_STRLIT   = 5'd3,
        TOK_PLUS     = 5'd4,
        TOK_DASH     = 5'd5,
        TOK_STAR     = 5'd6,
        TOK_SLASH    = 5'd7,
        TOK_SEMI     = 5'd8,
        TOK_SEP      = 5'd9,
        TOK_OPEN_PAR = 5'd10,
        TOK_CLOSE_PAR = 5'd11,
        TOK_DOT      = 5'd12,
        TOK_OPEN_BR  = 5'd13,
        TOK_CLOSE_BR = 5'd14,
        TOK_ASSIGN   = 5'd15,
        TOK_TYPE_SEP = 5'd16,
        TOK_EQ       = 5'd17,
        TOK_LE       = 5'd18,
        TOK_NE       = 5'd19,
        TOK_LT       = 5'd20,
        TOK_GE       = 5'd21,
        TOK_GT       = 5'd22,
        TOK_EOF      = 5'd23,
        TOK_UNCLOSED = 5'd24,
        TOK_INVALID  = 5'd25
    } tok_kind_t;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return is_upper(c) ? (c + 8'h20) : c;
    endfunction

    function automatic tok_kind_t op_kind(input logic [7:0] c);
        tok_kind_t k;
        unique case (c)
            8'h2B:    k = TOK_PLUS;
            8'h2D:    k = TOK_DASH;
            8'h2A:    k = TOK_STAR;
            8'h2F:    k = TOK_SLASH;
            8'h3B:    k = TOK_SEMI;
            8'h2C:    k = TOK_SEP;
            8'h28:    k = TOK_OPEN_PAR;
            8'h29:    k = TOK_CLOSE_PAR;
            CH_DOT:   k = TOK_DOT;
            8'h7B:    k = TOK_OPEN_BR;
            8'h7D:    k = TOK_CLOSE_BR;
            CH_COLON: k = TOK_TYPE_SEP;
            CH_EQ:    k = TOK_EQ;
            CH_LT:    k = TOK_LT;
            CH_GT:    k = TOK_GT;
            default:  k = TOK_INVALID;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/pascal_like_token_scanner_top.sv
// Top level of the token scanner: front end, result queue and output stage.
//
// The slave stream carries one source byte per transaction in s_tdata; s_tuser high marks
// the end of the source and the byte is then ignored. The master stream carries either a
// lexeme byte echo (m_tuser low) or a completed token (m_tuser high); m_tlast marks the last
// result caused by one input byte. An input byte gives zero, one or two results.
// The front end accepts one byte per cycle whenever the four-entry result queue has room,
// updates the scanner state in that same cycle and queues the results as one pair.
// The first result passes through the result queue and then the output register before m_tvalid rises.
// With the sink always ready, bytes stream at one per cycle as long as each gives at most
// one result; a byte that gives two results leaves the output register as two transactions,
// and the queue absorbs short bursts of these before s_tready drops.
// When the sink stalls, the output register holds its transaction unchanged and the queue
// fills; s_tready goes low once the queue is full.
// Synchronous reset (aresetn low) empties the queue, drops m_tvalid and returns the scanner
// to idle at line 1, column 0.
module pascal_like_token_scanner_top import pts_pkg::*; #(
    parameter int MAX_LEXEME  = 63,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12,
    localparam int LEN_BITS   = $clog2(MAX_LEXEME + 1),
    localparam int RES_W      = 1 + 5 + LINE_BITS + COLUMN_BITS + 8 + LEN_BITS + 1,
    localparam int ENTRY_W    = 2 * RES_W + 1,
    localparam int TDATA_W    = ((RES_W - 1 + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // char_in[7:0]
    input  logic [7:0]         s_tdata,
    // end_of_input
    input  logic               s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // token_kind, token_line, token_column, lexeme_byte, token_length, lexeme_truncated
    output logic [TDATA_W-1:0] m_tdata,
    // item_kind
    output logic               m_tuser,
    output logic               m_tlast
);

    q_status_t          q_status;
    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               pop;
    logic [ENTRY_W-1:0] head_data;
    logic [RES_W-1:0]   m_res;

    pts_front #(
        .MAX_LEXEME (MAX_LEXEME),
        .LINE_BITS  (LINE_BITS),
        .COLUMN_BITS(COLUMN_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .push_data(push_data)
    );

    pts_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head_data(head_data),
        .q_status (q_status)
    );

    pts_back #(
        .RES_W(RES_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_data(head_data),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = TDATA_W'(m_res[RES_W-2:0]);
    assign m_tuser = m_res[RES_W-1];

endmodule

>>> rtl/pts_front.sv
// Scanner front end: accepts source bytes, tracks position and token state, builds result pairs.
module pts_front import pts_pkg::*; #(
    parameter int MAX_LEXEME  = 63,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12,
    localparam int LEN_BITS   = $clog2(MAX_LEXEME + 1),
    localparam int RES_W      = 1 + 5 + LINE_BITS + COLUMN_BITS + 8 + LEN_BITS + 1,
    localparam int ENTRY_W    = 2 * RES_W + 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tuser,
    input  q_status_t           q_status,
    output logic                push,
    output logic [ENTRY_W-1:0]  push_data
);

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LEN_BITS-1:0]    LEN_MAX  = LEN_BITS'(MAX_LEXEME);

    scan_mode_t             mode_reg, mode_next;
    tok_kind_t              pend_reg, pend_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [LINE_BITS-1:0]   sl_reg, sl_next;
    logic [COLUMN_BITS-1:0] sc_reg, sc_next;
    logic [LEN_BITS-1:0]    cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;

    logic                   accept;
    logic                   eoi;
    logic [7:0]             ch;
    logic                   ch_nl;
    logic                   ch_dot;
    logic [COLUMN_BITS-1:0] col_inc;
    logic                   can_app;
    logic [LEN_BITS-1:0]    cnt_app;
    logic                   ovf_app;
    logic                   pair;
    tok_kind_t              pair_kind;
    logic                   cont;
    tok_kind_t              new_kind;
    scan_mode_t             new_mode;

    logic                   do_fin, do_echo, do_eof, echo_first;
    tok_kind_t              fin_kind, echo_kind;
    logic [LEN_BITS-1:0]    fin_len;
    logic                   fin_ovf;
    logic [LINE_BITS-1:0]   echo_line;
    logic [COLUMN_BITS-1:0] echo_col;
    logic [7:0]             echo_byte;

    logic [RES_W-1:0]       fin_res, echo_res, eof_res, first_res, second_res, r0;
    logic                   first_v, second_v;

    assign ch       = s_tdata;
    assign eoi      = s_tuser;
    assign ch_nl    = (ch == CH_NL);
    assign ch_dot   = (ch == CH_DOT);
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && !q_status.full;

    assign col_inc = (col_reg == COL_MAX) ? col_reg : col_reg + 1'b1;

    always_comb begin
        line_next = line_reg;
        col_next  = col_inc;
        if (!eoi && ch_nl) begin
            line_next = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;
            col_next  = '0;
        end
    end

    // Bytes past the maximum lexeme length are dropped and only flagged.
    assign can_app = (cnt_reg < LEN_MAX);
    assign cnt_app = can_app ? cnt_reg + 1'b1 : cnt_reg;
    assign ovf_app = ovf_reg | !can_app;

    always_comb begin
        pair_kind = TOK_ASSIGN;
        pair      = 1'b0;
        if (mode_reg == MODE_OP) begin
            priority if (pend_reg == TOK_TYPE_SEP && ch == CH_EQ) begin
                pair_kind = TOK_ASSIGN;
                pair      = 1'b1;
            end else if (pend_reg == TOK_LT && ch == CH_EQ) begin
                pair_kind = TOK_LE;
                pair      = 1'b1;
            end else if (pend_reg == TOK_LT && ch == CH_GT) begin
                pair_kind = TOK_NE;
                pair      = 1'b1;
            end else if (pend_reg == TOK_GT && ch == CH_EQ) begin
                pair_kind = TOK_GE;
                pair      = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (mode_reg)
            MODE_IDENT:  cont = is_alpha(ch) || is_digit(ch);
            MODE_INT:    cont = is_digit(ch) || ch_dot;
            MODE_REAL:   cont = is_digit(ch);
            MODE_STRING: cont = !ch_nl && (ch != CH_QUOTE);
            default:     cont = 1'b0;
        endcase
    end

    always_comb begin
        if (is_alpha(ch)) begin
            new_kind = TOK_IDENT;
            new_mode = MODE_IDENT;
        end else if (is_digit(ch)) begin
            new_kind = TOK_INT;
            new_mode = MODE_INT;
        end else begin
            new_kind = op_kind(ch);
            new_mode = MODE_OP;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        sl_next    = sl_reg;
        sc_next    = sc_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        do_fin     = 1'b0;
        fin_kind   = pend_reg;
        fin_len    = cnt_reg;
        fin_ovf    = ovf_reg;
        do_echo    = 1'b0;
        echo_kind  = pend_reg;
        echo_line  = sl_reg;
        echo_col   = sc_reg;
        echo_byte  = ch;
        do_eof     = 1'b0;
        echo_first = 1'b0;
        priority if (eoi) begin
            do_fin    = (mode_reg != MODE_IDLE);
            fin_kind  = (mode_reg == MODE_STRING) ? TOK_UNCLOSED : pend_reg;
            do_eof    = 1'b1;
            mode_next = MODE_IDLE;
        end else if (pair) begin
            // The second byte of a pair is echoed before the pair completes.
            echo_first = 1'b1;
            do_echo    = can_app;
            echo_kind  = pair_kind;
            do_fin     = 1'b1;
            fin_kind   = pair_kind;
            fin_len    = cnt_app;
            fin_ovf    = ovf_app;
            pend_next  = pair_kind;
            cnt_next   = cnt_app;
            ovf_next   = ovf_app;
            mode_next  = MODE_IDLE;
        end else if (cont) begin
            do_echo   = can_app;
            cnt_next  = cnt_app;
            ovf_next  = ovf_app;
            echo_byte = (mode_reg == MODE_IDENT) ? to_lower(ch) : ch;
            if (mode_reg == MODE_INT && ch_dot) begin
                echo_kind = TOK_REAL;
                pend_next = TOK_REAL;
                mode_next = MODE_REAL;
            end
        end else if (mode_reg == MODE_STRING) begin
            do_fin    = 1'b1;
            fin_kind  = ch_nl ? TOK_UNCLOSED : TOK_STRLIT;
            mode_next = MODE_IDLE;
        end else begin
            // The byte that ends a pending token also starts the next one unless it is white space.
            do_fin    = (mode_reg != MODE_IDLE);
            mode_next = MODE_IDLE;
            if (!is_space(ch)) begin
                sl_next  = line_next;
                sc_next  = col_next;
                cnt_next = '0;
                ovf_next = 1'b0;
                if (ch == CH_QUOTE) begin
                    mode_next = MODE_STRING;
                    pend_next = TOK_STRLIT;
                end else begin
                    mode_next = new_mode;
                    pend_next = new_kind;
                    cnt_next  = LEN_BITS'(1);
                    do_echo   = 1'b1;
                    echo_kind = new_kind;
                    echo_line = line_next;
                    echo_col  = col_next;
                    echo_byte = to_lower(ch);
                end
            end
        end
    end

    assign fin_res  = {1'b1, fin_ovf, fin_len, 8'h00, sc_reg, sl_reg, fin_kind};
    assign echo_res = {1'b0, 1'b0, {LEN_BITS{1'b0}}, echo_byte, echo_col, echo_line,
                       echo_kind};
    assign eof_res  = {1'b1, 1'b0, {LEN_BITS{1'b0}}, 8'h00, col_next, line_reg, TOK_EOF};

    always_comb begin
        if (do_eof) begin
            first_v    = do_fin;
            first_res  = fin_res;
            second_v   = 1'b1;
            second_res = eof_res;
        end else if (echo_first) begin
            first_v    = do_echo;
            first_res  = echo_res;
            second_v   = do_fin;
            second_res = fin_res;
        end else begin
            first_v    = do_fin;
            first_res  = fin_res;
            second_v   = do_echo;
            second_res = echo_res;
        end
    end

    assign r0        = first_v ? first_res : second_res;
    assign push      = accept && (first_v || second_v);
    assign push_data = {first_v && second_v, second_res, r0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pend_reg <= TOK_IDENT;
            line_reg <= LINE_BITS'(1);
            col_reg  <= '0;
            sl_reg   <= LINE_BITS'(1);
            sc_reg   <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            sl_reg   <= sl_next;
            sc_reg   <= sc_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

>>> rtl/pts_queue.sv
// Small register FIFO holding result pairs between the scanner front end and the output stage.
module pts_queue import pts_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output q_status_t        q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_data      = store_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/pts_back.sv
// Output stage: splits queued result pairs into single transactions and holds them for the sink.
module pts_back import pts_pkg::*; #(
    parameter int RES_W = 48
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [2*RES_W:0]   head_data,
    input  q_status_t          q_status,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [RES_W-1:0]   m_res,
    output logic               m_tlast
);

    logic             valid_reg, valid_next;
    logic             phase_reg, phase_next;
    logic [RES_W-1:0] res_reg;
    logic             last_reg;
    logic             take;
    logic             two;
    logic             is_last;
    logic [RES_W-1:0] sel_res;

    assign two     = head_data[2*RES_W];
    assign sel_res = phase_reg ? head_data[2*RES_W-1:RES_W] : head_data[RES_W-1:0];
    assign is_last = phase_reg || !two;

    // A new result loads whenever the output register is empty or being drained.
    assign take = (!valid_reg || m_tready) && !q_status.empty;
    assign pop  = take && is_last;

    always_comb begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        if (take) begin
            phase_next = !is_last;
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg  <= sel_res;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/pts_checker.sv
// Port-level assertions for the token scanner and the bind that attaches them.
module pts_checker import pts_pkg::*; #(
    parameter int MAX_LEXEME  = 63,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12,
    localparam int LEN_BITS   = $clog2(MAX_LEXEME + 1),
    localparam int RES_W      = 1 + 5 + LINE_BITS + COLUMN_BITS + 8 + LEN_BITS + 1,
    localparam int TDATA_W    = ((RES_W - 1 + 7) / 8) * 8
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tuser,
    input logic               m_tlast
);

    localparam int BYTE_LO  = 5 + LINE_BITS + COLUMN_BITS;
    localparam int LEN_LO   = BYTE_LO + 8;
    localparam int TRUNC_B  = LEN_LO + LEN_BITS;

    logic [4:0]          kind_f;
    logic [7:0]          byte_f;
    logic [LEN_BITS-1:0] len_f;
    logic                trunc_f;

    assign kind_f  = m_tdata[4:0];
    assign byte_f  = m_tdata[BYTE_LO +: 8];
    assign len_f   = m_tdata[LEN_LO +: LEN_BITS];
    assign trunc_f = m_tdata[TRUNC_B];

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output transaction changed");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_echo_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (len_f == '0) && !trunc_f)
        else $error("echo carries token length or truncation");

    a_token_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (byte_f == 8'h00))
        else $error("completed token carries a lexeme byte");

    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && (kind_f == TOK_EOF) |-> m_tlast && (len_f == '0))
        else $error("end-of-file token not last or not empty");

endmodule

bind pascal_like_token_scanner_top pts_checker #(
    .MAX_LEXEME (MAX_LEXEME),
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
) u_pts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
